// ----- hdl/bus3_pkg.sv -----
// Shared types, constants and helper functions for the 3x bilinear upscaler.
// No dependencies; imported by every module of the block.
`default_nettype none

package bus3_pkg;

  // Default sizing of the source image
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;

  // Width register
  localparam int unsigned CfgW = 11;
  localparam logic [CfgW-1:0] ImageWidthReset = 11'd512;

  // Payload widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned CoordW = 12;
  localparam int unsigned SumW   = 12;

  // Depth of the quad queue between front and back
  localparam int unsigned QueueDepth = 2;

  // ceil(2^16 / 9): exact truncating divide by nine for sums below 2304
  localparam int unsigned RecipShift = 16;
  localparam logic [12:0] Recip9     = 13'd7282;

  // Index of the last result within a 4x4 tile
  localparam logic [3:0] TileLastIdx = 4'd15;

  // One interpolation job: the 2x2 quad and the tile origin in output space
  typedef struct packed {
    logic [PixW-1:0]   a;
    logic [PixW-1:0]   b;
    logic [PixW-1:0]   c;
    logic [PixW-1:0]   d;
    logic [CoordW-1:0] base_row;
    logic [CoordW-1:0] base_col;
  } quad_t;

  // Pixel times a tile weight; weights are products of two values in 0..3
  function automatic logic [SumW-1:0] scale_px(input logic [PixW-1:0] px,
                                               input logic [3:0] w);
    logic [SumW-1:0] p;
    p = SumW'(px);
    case (w)
      4'd1:    scale_px = p;
      4'd2:    scale_px = p << 1;
      4'd3:    scale_px = (p << 1) + p;
      4'd4:    scale_px = p << 2;
      4'd6:    scale_px = (p << 2) + (p << 1);
      4'd9:    scale_px = (p << 3) + p;
      default: scale_px = '0;
    endcase
  endfunction

  // Product of two 2-bit factors
  function automatic logic [3:0] weight(input logic [1:0] x, input logic [1:0] y);
    weight = 4'(x) * 4'(y);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/bus3_front.sv -----
// Front end: accepts source pixels, tracks row/column, keeps the line buffer
// and forms 2x2 quads for interior pixels. Depends on bus3_pkg.
`default_nettype none

module bus3_front import bus3_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  input  wire logic            pix_valid_i,
  output logic                 pix_ready_o,
  input  wire logic [PixW-1:0] pix_i,
  input  wire logic            frame_start_i,
  output logic                 quad_valid_o,
  input  wire logic            quad_ready_i,
  output quad_t                quad_o
);

  localparam int unsigned AddrW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned RowW  = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int unsigned CmpW  = ($clog2(MaxWidth) + 1 > CfgW) ?
                                  $clog2(MaxWidth) + 1 : CfgW;

  // Width register
  logic [CfgW-1:0] width_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= ImageWidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  // Clamp the width to 2..MaxWidth
  logic [CmpW-1:0] width_ext, width_eff;
  always_comb begin
    width_ext = CmpW'(width_q);
    if (width_ext < CmpW'(2)) begin
      width_eff = CmpW'(2);
    end else if (width_ext > CmpW'(MaxWidth)) begin
      width_eff = CmpW'(MaxWidth);
    end else begin
      width_eff = width_ext;
    end
  end

  function automatic logic [RowW-1:0] next_row(input logic [RowW-1:0] r);
    next_row = (r == RowW'(MaxHeight - 1)) ? '0 : r + RowW'(1);
  endfunction

  // Stage 0: position of the incoming beat and counter update
  logic [AddrW-1:0] col_q, col_d, col0, col1;
  logic [RowW-1:0]  row_q, row_d, row0, row1;
  logic             accept;

  assign accept = pix_valid_i && pix_ready_o;

  always_comb begin
    col0 = frame_start_i ? '0 : col_q;
    row0 = frame_start_i ? '0 : row_q;
    if (CmpW'(col0) >= width_eff) begin
      col1 = '0;
      row1 = next_row(row0);
    end else begin
      col1 = col0;
      row1 = row0;
    end
    if (CmpW'(col1) + CmpW'(1) >= width_eff) begin
      col_d = '0;
      row_d = next_row(row1);
    end else begin
      col_d = col1 + AddrW'(1);
      row_d = row1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line buffer: read old entry, write new pixel at the same column
  logic [PixW-1:0] line_mem [MaxWidth];
  logic [PixW-1:0] upper_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      upper_q        <= line_mem[col1];
      line_mem[col1] <= pix_i;
    end
  end

  // Stage 1 holding register
  logic             s1_valid_q, s1_emit_q, s1_free;
  logic [PixW-1:0]  s1_pix_q;
  logic [RowW-1:0]  s1_row_q;
  logic [AddrW-1:0] s1_col_q;

  assign s1_free     = !s1_valid_q || !s1_emit_q || quad_ready_i;
  assign pix_ready_o = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pix_i;
      s1_row_q  <= row1;
      s1_col_q  <= col1;
      s1_emit_q <= (row1 != '0) && (col1 != '0);
    end
  end

  // Left neighbors: D and A for the next beat
  logic [PixW-1:0] left_cur_q, left_up_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cur_q <= '0;
      left_up_q  <= '0;
    end else if (s1_valid_q && s1_free) begin
      left_cur_q <= s1_pix_q;
      left_up_q  <= upper_q;
    end
  end

  // Quad and tile origin, 3*(row-1) and 3*(col-1)
  logic [CoordW-1:0] row_m1, col_m1;
  assign row_m1 = CoordW'(s1_row_q) - CoordW'(1);
  assign col_m1 = CoordW'(s1_col_q) - CoordW'(1);

  always_comb begin
    quad_o.a        = left_up_q;
    quad_o.b        = upper_q;
    quad_o.c        = s1_pix_q;
    quad_o.d        = left_cur_q;
    quad_o.base_row = (row_m1 << 1) + row_m1;
    quad_o.base_col = (col_m1 << 1) + col_m1;
  end

  assign quad_valid_o = s1_valid_q && s1_emit_q;

endmodule

`default_nettype wire

// ----- hdl/bus3_fifo.sv -----
// Short queue of quads between front and back end.
// Depends on bus3_pkg for quad_t.
`default_nettype none

module bus3_fifo import bus3_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_valid_i,
  output logic       wr_ready_o,
  input  wire quad_t wr_data_i,
  output logic       rd_valid_o,
  input  wire logic  rd_ready_i,
  output quad_t      rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  quad_t           slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= bump(wr_ptr_q);
      if (pop)  rd_ptr_q <= bump(rd_ptr_q);
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bus3_back.sv -----
// Back end: walks the 4x4 tile of a quad, one interpolated result per beat,
// into an output register. Depends on bus3_pkg.
`default_nettype none

module bus3_back import bus3_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          quad_valid_i,
  output logic               quad_ready_o,
  input  wire quad_t         quad_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output logic [CoordW-1:0]  res_row_o,
  output logic [CoordW-1:0]  res_col_o,
  output logic [PixW-1:0]    res_value_o,
  output logic               res_last_o
);

  quad_t      job_q;
  logic       busy_q;
  logic [3:0] idx_q;
  logic       advance, take;

  assign advance      = !res_valid_o || res_ready_i;
  assign quad_ready_o = advance && (!busy_q || idx_q == TileLastIdx);
  assign take         = quad_valid_i && quad_ready_o;

  // Tile position: k is the row step, l the column step
  logic [1:0] k, l;
  assign k = idx_q[3:2];
  assign l = idx_q[1:0];

  // Weighted sum and truncating divide by nine
  logic [SumW-1:0] sum;
  logic [24:0]     prod;
  always_comb begin
    sum = scale_px(job_q.a, weight(~l, ~k))
        + scale_px(job_q.b, weight(l, ~k))
        + scale_px(job_q.c, weight(l, k))
        + scale_px(job_q.d, weight(~l, k));
    prod = 25'(sum) * 25'(Recip9);
  end

  // Job sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (take) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (advance && busy_q) begin
      idx_q <= idx_q + 4'd1;
      if (idx_q == TileLastIdx) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) job_q <= quad_i;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else if (advance) begin
      res_valid_o <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && busy_q) begin
      res_row_o   <= job_q.base_row + CoordW'(k);
      res_col_o   <= job_q.base_col + CoordW'(l);
      res_value_o <= prod[RecipShift +: PixW];
      res_last_o  <= (idx_q == TileLastIdx);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bilinear_upscale_by_three_top.sv -----
// Top level of the 3x bilinear upscaler: front end, quad queue, back end.
// Depends on bus3_pkg, bus3_front, bus3_fifo and bus3_back.
`default_nettype none

// Source pixels enter in raster order, one per beat, with tuser marking the
// first pixel of a frame. Pixels in the first row or first column produce
// nothing; every other pixel produces a 4x4 tile of 16 results, which the
// output channel carries at one result per cycle while the receiver is ready.
// A two-entry quad queue lets the input side run ahead while a tile drains.
// The line buffer is not cleared after reset: the first row of a frame
// writes it before it is read, and image_width must only change while the
// block is idle.

module bilinear_upscale_by_three_top import bus3_pkg::*; #(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // image_width register
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  // source pixels
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [7:0]      s_axis_tdata,   // [7:0] pixel
  input  wire logic            s_axis_tuser,   // [0] frame_start
  // upscaled pixels
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // [11:0] out_row, [23:12] out_col,
                                               // [31:24] value
  output logic                 m_axis_tlast    // last beat of a tile
);

  quad_t front_quad, back_quad;
  logic  front_valid, front_ready, back_valid, back_ready;

  bus3_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pix_valid_i   (s_axis_tvalid),
    .pix_ready_o   (s_axis_tready),
    .pix_i         (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .quad_valid_o  (front_valid),
    .quad_ready_i  (front_ready),
    .quad_o        (front_quad)
  );

  bus3_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_data_i  (front_quad),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_data_o  (back_quad)
  );

  bus3_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .quad_valid_i (back_valid),
    .quad_ready_o (back_ready),
    .quad_i       (back_quad),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_row_o    (m_axis_tdata[11:0]),
    .res_col_o    (m_axis_tdata[23:12]),
    .res_value_o  (m_axis_tdata[31:24]),
    .res_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for the 3x bilinear upscaler: drives source pixels, predicts
// every 4x4 tile in a behavioral model and compares each output beat against it.
// Depends on bus3_pkg and bilinear_upscale_by_three_top.
module testbench;
  import bus3_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Scale      = 3;
  localparam int unsigned Settle     = 16;    // idle cycles before a width write
  localparam int unsigned EndSettle  = 40;    // idle cycles before the verdict
  localparam int unsigned HoldCycles = 400;   // long receiver back-pressure
  localparam int unsigned StallLimit = 4000;  // cycles with no beat on either side
  localparam int unsigned RandPixels = 384;

  typedef enum logic [1:0] {FEED_PIXEL, FEED_WIDTH, FEED_DRAIN, FEED_HOLD} feed_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOPPY} rx_mode_e;

  typedef struct packed {
    feed_kind_e      kind;
    logic [PixW-1:0] pixel;
    logic            frame_start;
    logic [CfgW-1:0] width;
  } feed_t;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [PixW-1:0]   value;
    logic              last;
  } upscaled_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i   = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata  = '0;
  logic            s_axis_tuser  = 1'b0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [31:0]     m_axis_tdata;
  logic            m_axis_tlast;

  bilinear_upscale_by_three_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stimulus and expected tiles
  feed_t     pixel_feed[$];
  upscaled_t upscaled_due[$];

  // Upscaler state as seen by the predictor
  bit [PixW-1:0] line_buf [MaxWidthDef];
  bit [PixW-1:0] left_cur, left_up;
  int unsigned   col_at, row_at;
  logic [CfgW-1:0] src_width = ImageWidthReset;

  // Bookkeeping
  int unsigned mismatches, pixels_in, beats_out, tiles_out, width_writes, row_wraps;
  int unsigned quiet_cycles, stall_cycles;
  int unsigned hold_reqs, holds_served, hold_left;
  int unsigned gap_left, burst_left = 1;
  int unsigned mode_left, rx_tick;
  rx_mode_e    rx_mode = RX_OPEN;

  function automatic int unsigned eff_width(input int unsigned w);
    if (w < 2) return 2;
    if (w > MaxWidthDef) return MaxWidthDef;
    return w;
  endfunction

  function automatic void close_row();
    col_at = 0;
    if (row_at + 1 >= MaxHeightDef) begin
      row_at = 0;
      row_wraps++;
    end else begin
      row_at = row_at + 1;
    end
  endfunction

  // Advance the line state by one source pixel and queue the tile it completes, if any
  task automatic interpolate_tile(input logic [PixW-1:0] px, input logic fs);
    int unsigned wd, col, row, a, b, c, d, k, l, sum;
    upscaled_t   beat;
    wd = eff_width(src_width);
    if (fs) begin
      col_at = 0;
      row_at = 0;
    end
    if (col_at >= wd) close_row();
    col = col_at;
    row = row_at;
    a = left_up;
    d = left_cur;
    b = line_buf[col % MaxWidthDef];
    c = px;
    if (row > 0 && col > 0) begin
      for (k = 0; k <= Scale; k++) begin
        for (l = 0; l <= Scale; l++) begin
          sum = a * (Scale - l) * (Scale - k) + b * l * (Scale - k)
              + c * l * k + d * (Scale - l) * k;
          beat.row   = CoordW'(Scale * (row - 1) + k);
          beat.col   = CoordW'(Scale * (col - 1) + l);
          beat.value = PixW'(sum / (Scale * Scale));
          beat.last  = (k == Scale && l == Scale);
          upscaled_due.push_back(beat);
        end
      end
    end
    left_up  = PixW'(b);
    left_cur = px;
    line_buf[col % MaxWidthDef] = px;
    if (col + 1 >= wd) close_row();
    else col_at = col + 1;
  endtask

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (mismatches < 20)
      $display("mismatch on %s at output beat %0d: got %0d, want %0d",
               what, beats_out, got, want);
    mismatches++;
  endtask

  // Source side driver: bursts with random gaps, markers for width writes and pauses
  always @(posedge clk_i) begin
    feed_t head;
    logic  offer;
    logic  we;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      cfg_we_i      <= 1'b0;
      cfg_wdata_i   <= '0;
    end else begin
      offer = s_axis_tvalid && !s_axis_tready;
      we    = 1'b0;
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pixel_feed.size() != 0) begin
          head = pixel_feed[0];
          case (head.kind)
            FEED_PIXEL: begin
              s_axis_tdata <= head.pixel;
              s_axis_tuser <= head.frame_start;
              offer = 1'b1;
              void'(pixel_feed.pop_front());
              if (burst_left > 1) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(1, 32);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
              end
            end
            FEED_WIDTH, FEED_DRAIN: begin
              // block must be idle: no beat in flight and nothing due for a while
              if (!s_axis_tvalid && quiet_cycles >= Settle) begin
                if (head.kind == FEED_WIDTH) begin
                  we = 1'b1;
                  cfg_wdata_i <= head.width;
                end
                void'(pixel_feed.pop_front());
              end
            end
            default: begin
              hold_reqs <= hold_reqs + 1;
              void'(pixel_feed.pop_front());
            end
          endcase
        end
      end
      cfg_we_i      <= we;
      s_axis_tvalid <= offer;
    end
  end

  // Result side: rotating ready patterns plus a long hold on request
  always @(posedge clk_i) begin
    logic rdy;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_left == 0 && holds_served != hold_reqs) begin
        hold_left = HoldCycles;
        holds_served++;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        rx_tick++;
        case (rx_mode)
          RX_OPEN: rdy = 1'b1;
          RX_COIN: rdy = ($urandom_range(0, 2) != 0);
          default: rdy = ((rx_tick % 7) < 4);
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // Monitor: register writes, accepted pixels, output beats and the watchdog
  always @(posedge clk_i) begin
    upscaled_t got, want;
    logic      in_beat, out_beat;
    if (rst_ni) begin
      in_beat  = s_axis_tvalid && s_axis_tready;
      out_beat = m_axis_tvalid && m_axis_tready;
      if (cfg_we_i) begin
        src_width = cfg_wdata_i;
        width_writes++;
      end
      if (in_beat) begin
        interpolate_tile(s_axis_tdata, s_axis_tuser);
        pixels_in++;
      end
      if (out_beat) begin
        got.row   = m_axis_tdata[11:0];
        got.col   = m_axis_tdata[23:12];
        got.value = m_axis_tdata[31:24];
        got.last  = m_axis_tlast;
        if (upscaled_due.size() == 0) begin
          flag_mismatch("beat with no tile due (value)", got.value, 0);
        end else begin
          want = upscaled_due.pop_front();
          if (got.row !== want.row)     flag_mismatch("out_row", got.row, want.row);
          if (got.col !== want.col)     flag_mismatch("out_col", got.col, want.col);
          if (got.value !== want.value) flag_mismatch("value", got.value, want.value);
          if (got.last !== want.last)   flag_mismatch("tlast", got.last, want.last);
        end
        beats_out++;
        if (got.last === 1'b1) tiles_out++;
      end
      if (in_beat || out_beat || upscaled_due.size() != 0) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_beat || out_beat) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no beat accepted for %0d cycles, %0d beats still due",
                 stall_cycles, upscaled_due.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic queue_pixel(input logic [PixW-1:0] px, input logic fs);
    feed_t f;
    f.kind        = FEED_PIXEL;
    f.pixel       = px;
    f.frame_start = fs;
    f.width       = '0;
    pixel_feed.push_back(f);
  endtask

  task automatic queue_marker(input feed_kind_e kind, input int unsigned w);
    feed_t f;
    f.kind        = kind;
    f.pixel       = '0;
    f.frame_start = 1'b0;
    f.width       = CfgW'(w);
    pixel_feed.push_back(f);
  endtask

  // Mostly uniform, with a bias toward the two rails
  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PixW'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned budget, v, eff, rows, n, i;
    bit          first;

    // Reset width, no frame marker: counters start at row 0, so nothing comes out
    for (i = 0; i < 8; i++) queue_pixel(i == 0 ? 8'h00 : pick_pixel(), 1'b0);

    // Width below range acts as two; rail values in every corner of the quad
    queue_marker(FEED_WIDTH, 0);
    queue_pixel(8'hFF, 1'b1);
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'hFF, 1'b0);
    queue_pixel(8'h00, 1'b0);
    queue_marker(FEED_WIDTH, 1);
    queue_pixel(8'h55, 1'b0);
    queue_pixel(8'hAA, 1'b0);
    queue_pixel(8'hAA, 1'b0);
    queue_pixel(8'h55, 1'b0);

    // Width lowered in the middle of a row, then a frame restart mid-row
    queue_marker(FEED_WIDTH, 8);
    for (i = 0; i < 11; i++) queue_pixel(pick_pixel(), i == 0);
    queue_marker(FEED_WIDTH, 4);
    for (i = 0; i < 3; i++) queue_pixel(pick_pixel(), 1'b0);
    for (i = 0; i < 6; i++) queue_pixel(pick_pixel(), i == 0);

    // Width above range clamps to the line buffer; a short first row only
    queue_marker(FEED_WIDTH, 2047);
    for (i = 0; i < 6; i++) queue_pixel(pick_pixel(), i == 0);

    // Random frames; the first one runs into a long receiver hold
    budget = RandPixels;
    first  = 1'b1;
    eff    = 2;
    while (budget > 0) begin
      if (first) begin
        v = 8;
      end else begin
        case ($urandom_range(0, 19))
          0, 1:       v = $urandom_range(0, 1);
          2, 3, 4:    v = $urandom_range(13, 40);
          default:    v = $urandom_range(2, 12);
        endcase
      end
      queue_marker(FEED_WIDTH, v);
      eff = eff_width(v);
      if (first) queue_marker(FEED_HOLD, 0);
      rows = first ? 4 : $urandom_range(2, 5);
      n    = eff * rows;
      if (!first && $urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      if (n > budget) n = budget;
      for (i = 0; i < n; i++) begin
        queue_pixel(pick_pixel(), i == 0 || $urandom_range(0, 39) == 0);
        // narrowing mid-frame only reads line buffer entries already written
        if (eff > 2 && $urandom_range(0, 59) == 0) begin
          eff = $urandom_range(2, eff - 1);
          queue_marker(FEED_WIDTH, eff);
        end
      end
      if ($urandom_range(0, 3) == 0) queue_marker(FEED_DRAIN, 0);
      budget = budget - n;
      first  = 1'b0;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_feed.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (quiet_cycles < EndSettle) @(negedge clk_i);

    $display("covered %0d source pixels, %0d output beats in %0d tiles, %0d width writes",
             pixels_in, beats_out, tiles_out, width_writes);
    $display("including clamped widths, mid-row narrowing, frame restarts, %0d row wrap(s)",
             row_wraps);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- bilinear_upscale_by_three_top.f -----
hdl/bus3_pkg.sv
hdl/bus3_front.sv
hdl/bus3_fifo.sv
hdl/bus3_back.sv
hdl/bilinear_upscale_by_three_top.sv
tb/testbench.sv
